// ----- hdl/stochastic_sandpile_avalanche_top_defines.svh -----
// Assertion macros used by the sandpile avalanche datapath.
`ifndef STOCHASTIC_SANDPILE_AVALANCHE_TOP_DEFINES_SVH
`define STOCHASTIC_SANDPILE_AVALANCHE_TOP_DEFINES_SVH

// Same-cycle implication.
`define SSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssa assertion failed");

// Next-cycle implication.
`define SSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssa assertion failed");

`endif

// ----- hdl/ssa_pkg.sv -----
// Types, constants and helper functions of the sandpile avalanche block.
package ssa_pkg;

   localparam int ROW_COUNT = 2048;
   localparam int CELLS     = ROW_COUNT + 2;
   localparam int POS_W     = $clog2(CELLS + 1);
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int I_W       = $clog2(ROW_COUNT + 1);
   localparam int H_W       = 4;
   localparam int DIV_W     = 5;
   localparam int LEN_W     = 12;
   localparam int CNT_W     = 32;
   localparam int AREA_W    = 22;
   localparam int WIDTH_W   = 12;

   localparam logic [H_W-1:0]    HEIGHT_MAX    = 4'd15;
   localparam logic [H_W-1:0]    TOPPLE_LEVEL  = 4'd2;
   localparam logic [31:0]       SEED_AT_RESET = 32'd2463534242;
   localparam logic [DIV_W-1:0]  DIV_RESET     = 5'd4;
   localparam logic [AREA_W-1:0] AREA_MAX      = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

   localparam int MOD_BITS   = 4;
   localparam int MOD_CYCLES = 32 / MOD_BITS;
   localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

   typedef struct packed {
      logic        reseed;
      logic [31:0] seed_value;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]   length_rows;
      logic [CNT_W-1:0]   toppling_count;
      logic [AREA_W-1:0]  touched_area;
      logic [WIDTH_W-1:0] max_width;
   } rsp_type;

   typedef struct packed {
      logic           touched;
      logic [H_W-1:0] height;
   } cell_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_START,
      OP_REFRESH,
      OP_SEED,
      OP_PASS_INIT,
      OP_RD_B,
      OP_RD_C,
      OP_CHECK,
      OP_APPLY,
      OP_WB_A,
      OP_WB_B,
      OP_NEXT_ROW,
      OP_AREA_ACC,
      OP_UNION,
      OP_SPAN_COPY,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      logic init_last;
      logic at_hi;
      logic pass_empty;
      logic can_topple;
      logic mod_done;
      logic wb_last;
      logic toppled;
      logic last_row;
      logic area_last;
      logic rsp_busy;
   } dp_status_type;

   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] x;
      x = s ^ (s << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   function automatic cell_type cell_add(input cell_type c, input logic [1:0] amt);
      logic [H_W:0] s;
      cell_type     o;
      s = (H_W+1)'(c.height) + (H_W+1)'(amt);
      o.touched = 1'b1;
      o.height  = (s > (H_W+1)'(HEIGHT_MAX)) ? HEIGHT_MAX : s[H_W-1:0];
      return o;
   endfunction

endpackage

// ----- hdl/ssa_mod.sv -----
// Multi-cycle remainder unit: 32-bit value modulo a 5-bit divisor, 4 bits per cycle.
module ssa_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               dividend,
   input  logic [ssa_pkg::DIV_W-1:0] divisor,
   output logic                      busy,
   output logic                      done,
   output logic [ssa_pkg::DIV_W-1:0] rem
);
   import ssa_pkg::*;

   logic [31:0]          q_ff, q_in;
   logic [DIV_W-1:0]     r_ff, r_in, z_ff, z_in, r_step;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      logic [DIV_W:0] t;
      r_step = r_ff;
      for (int k = 0; k < MOD_BITS; k++) begin
         t = {r_step, q_ff[31-k]};
         if (t >= {1'b0, z_ff}) begin
            t = t - {1'b0, z_ff};
         end
         r_step = t[DIV_W-1:0];
      end
   end

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         z_in    = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = q_ff << MOD_BITS;
         r_in   = r_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MOD_CNT_W'(MOD_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      z_ff <= z_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = r_ff;

endmodule

// ----- hdl/ssa_dp.sv -----
// Datapath: row stores, generator, span and result registers of the avalanche.
`include "stochastic_sandpile_avalanche_top_defines.svh"

module ssa_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  ssa_pkg::dp_op_type        op,
   output ssa_pkg::dp_status_type    status,
   input  ssa_pkg::req_type          req_data,
   input  logic                      csr_wr_en,
   input  logic [ssa_pkg::DIV_W-1:0] csr_wr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ssa_pkg::rsp_type          rsp_data
);
   import ssa_pkg::*;

   cell_type mem0 [CELLS];
   cell_type mem1 [CELLS];
   cell_type q0_ff, q1_ff;

   logic [DIV_W-1:0]  div_ff, div_in;
   logic [31:0]       prng_ff, prng_in, draw;
   logic [POS_W-1:0]  j_ff, j_in, j_p1;
   logic [POS_W-1:0]  span_low_ff, span_low_in, span_high_ff, span_high_in;
   logic [POS_W-1:0]  prev_low_ff, prev_low_in, prev_high_ff, prev_high_in;
   logic [POS_W-1:0]  pass_hi_ff, pass_hi_in, area_hi_ff, area_hi_in;
   logic [POS_W-1:0]  widest_ff, widest_in;
   logic [POS_W-1:0]  union_lo, union_hi_raw, union_hi, pass_hi_c, width_c;
   logic              tgt_ff, tgt_in, cur_ff, cur_in, toppled_ff, toppled_in;
   logic [I_W-1:0]    i_ff, i_in;
   logic [H_W-1:0]    h_ff, h_in;
   logic              hflag_ff, hflag_in;
   cell_type          a0_ff, a0_in, a1_ff, a1_in, cur_q, nxt_q;
   logic [CNT_W-1:0]  topple_ff, topple_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              we0, we1;
   logic [ADDR_W-1:0] wa0, wa1, ra0, ra1;
   cell_type          wd0, wd1, rnd_cell;

   logic              can_topple, mod_start, mod_busy, mod_done;
   logic [DIV_W-1:0]  mod_rem, z;

   assign draw         = xorshift32(prng_ff);
   assign j_p1         = j_ff + 1'b1;
   assign union_lo     = (prev_low_ff < span_low_ff) ? prev_low_ff : span_low_ff;
   assign union_hi_raw = (prev_high_ff > span_high_ff) ? prev_high_ff : span_high_ff;
   assign union_hi     = (union_hi_raw > POS_W'(CELLS - 1)) ? POS_W'(CELLS - 1) : union_hi_raw;
   assign pass_hi_c    = (prev_high_ff > POS_W'(CELLS - 2)) ? POS_W'(CELLS - 2) : prev_high_ff;
   assign width_c      = span_high_ff - span_low_ff + 1'b1;
   assign cur_q        = cur_ff ? q1_ff : q0_ff;
   assign nxt_q        = cur_ff ? q0_ff : q1_ff;
   assign can_topple   = (h_ff >= TOPPLE_LEVEL);
   assign mod_start    = (op == OP_CHECK) && can_topple;
   assign z            = (div_ff == '0) ? DIV_W'(1) : div_ff;
   assign rnd_cell     = cell_type'{touched: 1'b0, height: H_W'(draw[0])};

   ssa_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (draw),
      .divisor  (z),
      .busy     (mod_busy),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   // row store ports
   always_comb begin
      we0 = 1'b0;
      we1 = 1'b0;
      wa0 = j_ff[ADDR_W-1:0];
      wa1 = j_ff[ADDR_W-1:0];
      wd0 = rnd_cell;
      wd1 = rnd_cell;
      ra0 = (cur_ff && op == OP_RD_B) ? j_p1[ADDR_W-1:0] : j_ff[ADDR_W-1:0];
      ra1 = (!cur_ff && op == OP_RD_B) ? j_p1[ADDR_W-1:0] : j_ff[ADDR_W-1:0];
      case (op)
         OP_INIT, OP_REFRESH: begin
            we0 = !tgt_ff;
            we1 = tgt_ff;
         end
         OP_SEED: begin
            we0 = 1'b1;
            wa0 = '0;
            wd0 = cell_type'{touched: 1'b0, height: TOPPLE_LEVEL};
         end
         OP_WB_A: begin
            we0 = 1'b1;
            we1 = 1'b1;
            wd0 = cur_ff ? a0_ff : cell_type'{touched: hflag_ff, height: h_ff};
            wd1 = cur_ff ? cell_type'{touched: hflag_ff, height: h_ff} : a0_ff;
         end
         OP_WB_B: begin
            we0 = cur_ff;
            we1 = !cur_ff;
            wa0 = j_p1[ADDR_W-1:0];
            wa1 = j_p1[ADDR_W-1:0];
            wd0 = a1_ff;
            wd1 = a1_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         mem0[wa0] <= wd0;
      end
      if (we1) begin
         mem1[wa1] <= wd1;
      end
      q0_ff <= mem0[ra0];
      q1_ff <= mem1[ra1];
   end

   always_comb begin
      div_in       = csr_wr_en ? csr_wr_data : div_ff;
      prng_in      = prng_ff;
      j_in         = j_ff;
      span_low_in  = span_low_ff;
      span_high_in = span_high_ff;
      prev_low_in  = prev_low_ff;
      prev_high_in = prev_high_ff;
      pass_hi_in   = pass_hi_ff;
      area_hi_in   = area_hi_ff;
      widest_in    = widest_ff;
      tgt_in       = tgt_ff;
      cur_in       = cur_ff;
      toppled_in   = toppled_ff;
      i_in         = i_ff;
      h_in         = h_ff;
      hflag_in     = hflag_ff;
      a0_in        = a0_ff;
      a1_in        = a1_ff;
      topple_in    = topple_ff;
      area_in      = area_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (op)
         OP_INIT: begin
            prng_in = draw;
            if (j_ff == POS_W'(CELLS - 1)) begin
               j_in   = '0;
               tgt_in = !tgt_ff;
            end else begin
               j_in = j_p1;
            end
         end
         OP_START: begin
            if (req_data.reseed) begin
               prng_in = (req_data.seed_value == '0) ? SEED_AT_RESET : req_data.seed_value;
            end
            topple_in    = '0;
            area_in      = AREA_W'(1);
            widest_in    = POS_W'(1);
            i_in         = '0;
            prev_low_in  = union_lo;
            prev_high_in = union_hi;
            j_in         = union_lo;
            tgt_in       = 1'b0;
         end
         OP_REFRESH: begin
            prng_in = draw;
            if (j_ff == prev_high_ff) begin
               j_in   = prev_low_ff;
               tgt_in = !tgt_ff;
            end else begin
               j_in = j_p1;
            end
         end
         OP_SEED: begin
            prev_low_in  = '0;
            prev_high_in = '0;
            cur_in       = 1'b0;
         end
         OP_PASS_INIT: begin
            span_low_in  = prev_high_ff + 1'b1;
            span_high_in = prev_low_ff;
            j_in         = prev_low_ff;
            pass_hi_in   = pass_hi_c;
            toppled_in   = 1'b0;
         end
         OP_RD_B: begin
            h_in     = cur_q.height;
            hflag_in = cur_q.touched;
            a0_in    = nxt_q;
         end
         OP_RD_C: begin
            a1_in = nxt_q;
         end
         OP_CHECK: begin
            if (can_topple) begin
               if (topple_ff != CNT_MAX) begin
                  topple_in = topple_ff + 1'b1;
               end
               toppled_in = 1'b1;
               h_in       = h_ff - TOPPLE_LEVEL;
               prng_in    = draw;
            end
         end
         OP_APPLY: begin
            if (mod_rem == DIV_W'(0)) begin
               a0_in = cell_add(a0_ff, 2'd2);
               if (j_ff < span_low_ff) span_low_in = j_ff;
               if (j_ff > span_high_ff) span_high_in = j_ff;
            end else if (mod_rem == DIV_W'(1)) begin
               a1_in = cell_add(a1_ff, 2'd2);
               if (j_p1 < span_low_ff) span_low_in = j_p1;
               if (j_p1 > span_high_ff) span_high_in = j_p1;
            end else begin
               a0_in = cell_add(a0_ff, 2'd1);
               a1_in = cell_add(a1_ff, 2'd1);
               if (j_ff < span_low_ff) span_low_in = j_ff;
               if (j_p1 > span_high_ff) span_high_in = j_p1;
            end
         end
         OP_WB_B: begin
            j_in = j_p1;
         end
         OP_NEXT_ROW: begin
            i_in       = i_ff + 1'b1;
            cur_in     = !cur_ff;
            j_in       = span_low_ff;
            area_hi_in = (span_high_ff > POS_W'(CELLS - 1)) ? POS_W'(CELLS - 1) : span_high_ff;
            if (width_c > widest_ff) begin
               widest_in = width_c;
            end
         end
         OP_AREA_ACC: begin
            if (cur_q.touched && area_ff != AREA_MAX) begin
               area_in = area_ff + 1'b1;
            end
            j_in = j_p1;
         end
         OP_UNION: begin
            prev_low_in  = union_lo;
            prev_high_in = union_hi;
            j_in         = union_lo;
            tgt_in       = !cur_ff;
         end
         OP_SPAN_COPY: begin
            prev_low_in  = span_low_ff;
            prev_high_in = span_high_ff;
         end
         OP_FINISH: begin
            rsp_data_in.length_rows    = LEN_W'(i_ff);
            rsp_data_in.toppling_count = topple_ff;
            rsp_data_in.touched_area   = area_ff;
            rsp_data_in.max_width      = WIDTH_W'(widest_ff);
            rsp_valid_in               = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff       <= DIV_RESET;
         prng_ff      <= SEED_AT_RESET;
         j_ff         <= '0;
         span_low_ff  <= '0;
         span_high_ff <= POS_W'(ROW_COUNT);
         prev_low_ff  <= '0;
         prev_high_ff <= POS_W'(ROW_COUNT);
         pass_hi_ff   <= '0;
         area_hi_ff   <= '0;
         widest_ff    <= POS_W'(1);
         tgt_ff       <= 1'b0;
         cur_ff       <= 1'b0;
         toppled_ff   <= 1'b0;
         i_ff         <= '0;
         topple_ff    <= '0;
         area_ff      <= AREA_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         div_ff       <= div_in;
         prng_ff      <= prng_in;
         j_ff         <= j_in;
         span_low_ff  <= span_low_in;
         span_high_ff <= span_high_in;
         prev_low_ff  <= prev_low_in;
         prev_high_ff <= prev_high_in;
         pass_hi_ff   <= pass_hi_in;
         area_hi_ff   <= area_hi_in;
         widest_ff    <= widest_in;
         tgt_ff       <= tgt_in;
         cur_ff       <= cur_in;
         toppled_ff   <= toppled_in;
         i_ff         <= i_in;
         topple_ff    <= topple_in;
         area_ff      <= area_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      hflag_ff    <= hflag_in;
      a0_ff       <= a0_in;
      a1_ff       <= a1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.init_last  = (j_ff == POS_W'(CELLS - 1)) && tgt_ff;
   assign status.at_hi      = (j_ff == prev_high_ff);
   assign status.pass_empty = (prev_low_ff > pass_hi_c);
   assign status.can_topple = can_topple;
   assign status.mod_done   = mod_done;
   assign status.wb_last    = (j_ff == pass_hi_ff);
   assign status.toppled    = toppled_ff;
   assign status.last_row   = (i_ff == I_W'(ROW_COUNT));
   assign status.area_last  = (j_ff == area_hi_ff);
   assign status.rsp_busy   = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SSA_ASSERT_NOW(a_mod_free, clock, reset, mod_start, !mod_busy)
   `SSA_ASSERT_NEXT(a_span_order, clock, reset, op == OP_APPLY, span_low_ff <= span_high_ff)
   `SSA_ASSERT_NOW(a_rsp_free, clock, reset, op == OP_FINISH, !rsp_valid_ff)

endmodule

// ----- hdl/ssa_ctrl.sv -----
// Controller state machine sequencing the avalanche datapath.
module ssa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ssa_pkg::dp_status_type status,
   output ssa_pkg::dp_op_type     op
);
   import ssa_pkg::*;

   typedef enum logic [20:0] {
      ST_INIT      = 21'h000001,
      ST_IDLE      = 21'h000002,
      ST_RB0       = 21'h000004,
      ST_RB1       = 21'h000008,
      ST_SEED      = 21'h000010,
      ST_PASS_INIT = 21'h000020,
      ST_RD_A      = 21'h000040,
      ST_RD_B      = 21'h000080,
      ST_RD_C      = 21'h000100,
      ST_CHECK     = 21'h000200,
      ST_DIV       = 21'h000400,
      ST_APPLY     = 21'h000800,
      ST_WB_A      = 21'h001000,
      ST_WB_B      = 21'h002000,
      ST_PASS_END  = 21'h004000,
      ST_AREA_RD   = 21'h008000,
      ST_AREA_ACC  = 21'h010000,
      ST_UNION     = 21'h020000,
      ST_RONE      = 21'h040000,
      ST_SPAN_COPY = 21'h080000,
      ST_DONE      = 21'h100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            op = OP_INIT;
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_START;
               state_in = ST_RB0;
            end
         end
         ST_RB0: begin
            op = OP_REFRESH;
            if (status.at_hi) state_in = ST_RB1;
         end
         ST_RB1: begin
            op = OP_REFRESH;
            if (status.at_hi) state_in = ST_SEED;
         end
         ST_SEED: begin
            op       = OP_SEED;
            state_in = ST_PASS_INIT;
         end
         ST_PASS_INIT: begin
            op       = OP_PASS_INIT;
            state_in = status.pass_empty ? ST_PASS_END : ST_RD_A;
         end
         ST_RD_A: begin
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            op       = OP_RD_B;
            state_in = ST_RD_C;
         end
         ST_RD_C: begin
            op       = OP_RD_C;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            op       = OP_CHECK;
            state_in = status.can_topple ? ST_DIV : ST_WB_A;
         end
         ST_DIV: begin
            if (status.mod_done) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            op       = OP_APPLY;
            state_in = ST_CHECK;
         end
         ST_WB_A: begin
            op       = OP_WB_A;
            state_in = ST_WB_B;
         end
         ST_WB_B: begin
            op       = OP_WB_B;
            state_in = status.wb_last ? ST_PASS_END : ST_RD_A;
         end
         ST_PASS_END: begin
            if (status.toppled && !status.last_row) begin
               op       = OP_NEXT_ROW;
               state_in = ST_AREA_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_AREA_RD: begin
            state_in = ST_AREA_ACC;
         end
         ST_AREA_ACC: begin
            op       = OP_AREA_ACC;
            state_in = status.area_last ? ST_UNION : ST_AREA_RD;
         end
         ST_UNION: begin
            op       = OP_UNION;
            state_in = ST_RONE;
         end
         ST_RONE: begin
            op = OP_REFRESH;
            if (status.at_hi) state_in = ST_SPAN_COPY;
         end
         ST_SPAN_COPY: begin
            op       = OP_SPAN_COPY;
            state_in = ST_PASS_INIT;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               op       = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/stochastic_sandpile_avalanche_top.sv -----
// Top level of the directed stochastic sandpile avalanche block.
// Reset: a sweep fills both row stores from the generator; no request is taken meanwhile.
// Per request (data dependent): both rows refresh over the span; per row, each span cell is read,
// toppled (remainder wait per toppling), written back; then next-row area and one row refresh.
// One avalanche at a time; the result register lets the next request in while a result waits.
module stochastic_sandpile_avalanche_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ssa_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ssa_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [ssa_pkg::DIV_W-1:0] csr_wr_data
);
   import ssa_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   ssa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- tb/stochastic_sandpile_avalanche_checker.sv -----
// Checker for the sandpile avalanche block: watches both channels, predicts results and compares.
`timescale 1ns / 1ps

module stochastic_sandpile_avalanche_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  ssa_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  ssa_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [ssa_pkg::DIV_W-1:0] csr_wr_data,
   output int                        fail_count,
   output int                        pending_count,
   output int                        results_seen
);
   import ssa_pkg::*;

   logic [H_W-1:0]   pile[2][CELLS];
   bit               hit[2][CELLS];
   logic [31:0]      gen;
   int unsigned      out_lo, out_hi, in_lo, in_hi;
   logic [DIV_W-1:0] divisor;
   logic [31:0]      topples;
   rsp_type          avalanche_q[$];

   function automatic logic [31:0] next_draw();
      gen = gen ^ (gen << 13);
      gen = gen ^ (gen >> 17);
      gen = gen ^ (gen << 5);
      return gen;
   endfunction

   function automatic void pile_reset();
      gen = SEED_AT_RESET;
      divisor = DIV_RESET;
      for (int r = 0; r < 2; r++)
         for (int j = 0; j < CELLS; j++) begin
            pile[r][j] = 4'(next_draw() & 1);
            hit[r][j] = 0;
         end
      out_lo = 0;
      out_hi = ROW_COUNT;
      in_lo = 0;
      in_hi = ROW_COUNT;
   endfunction

   function automatic void drop_grains(int row, int unsigned j, int amt);
      int h;
      h = int'(pile[row][j]) + amt;
      pile[row][j] = (h > 15) ? 4'd15 : 4'(h);
      hit[row][j] = 1;
   endfunction

   function automatic void refresh_rows(int row, bit both);
      int unsigned lo, hi;
      lo = (in_lo < out_lo) ? in_lo : out_lo;
      hi = (in_hi > out_hi) ? in_hi : out_hi;
      if (hi > CELLS - 1) hi = CELLS - 1;
      in_lo = lo;
      in_hi = hi;
      for (int r = 0; r < 2; r++) begin
         int tgt;
         tgt = both ? r : row;
         for (int unsigned j = lo; j <= hi; j++) pile[tgt][j] = 4'(next_draw() & 1);
         if (both) begin
            for (int j = 0; j < CELLS; j++) hit[tgt][j] = 0;
         end else begin
            for (int unsigned j = lo; j <= hi; j++) hit[tgt][j] = 0;
         end
         if (!both) break;
      end
   endfunction

   function automatic bit topple_row(int cur);
      int nxt;
      int unsigned z, lo, hi, r;
      bit any;
      nxt = cur ^ 1;
      z = (divisor == 0) ? 1 : divisor;
      lo = in_lo;
      hi = in_hi;
      any = 0;
      out_lo = hi + 1;
      out_hi = lo;
      if (hi > CELLS - 2) hi = CELLS - 2;
      for (int unsigned j = lo; j <= hi; j++) begin
         while (pile[cur][j] >= TOPPLE_LEVEL) begin
            if (topples != CNT_MAX) topples++;
            any = 1;
            pile[cur][j] = pile[cur][j] - TOPPLE_LEVEL;
            r = next_draw() % z;
            if (r == 0) begin
               drop_grains(nxt, j, 2);
               if (j < out_lo) out_lo = j;
               if (j > out_hi) out_hi = j;
            end else if (r == 1) begin
               drop_grains(nxt, j + 1, 2);
               if (j + 1 < out_lo) out_lo = j + 1;
               if (j + 1 > out_hi) out_hi = j + 1;
            end else begin
               drop_grains(nxt, j, 1);
               drop_grains(nxt, j + 1, 1);
               if (j < out_lo) out_lo = j;
               if (j + 1 > out_hi) out_hi = j + 1;
            end
         end
      end
      return any;
   endfunction

   function automatic rsp_type run_avalanche(req_type rq);
      int unsigned area, widest, len, i, hi, w;
      bit going;
      rsp_type res;
      area = 1;
      widest = 1;
      len = 0;
      i = 0;
      if (rq.reseed) gen = (rq.seed_value != 0) ? rq.seed_value : SEED_AT_RESET;
      topples = 0;
      refresh_rows(0, 1);
      pile[0][0] = TOPPLE_LEVEL;
      in_lo = 0;
      in_hi = 0;
      going = topple_row(0);
      while (going) begin
         i++;
         if (i >= ROW_COUNT + 1) break;
         len = (i > 4095) ? 4095 : i;
         hi = (out_hi > CELLS - 1) ? CELLS - 1 : out_hi;
         for (int unsigned j = out_lo; j <= hi; j++)
            if (hit[i & 1][j] && area < AREA_MAX) area++;
         w = out_hi - out_lo + 1;
         if (widest < w) widest = w;
         refresh_rows((i & 1) ^ 1, 0);
         in_lo = out_lo;
         in_hi = out_hi;
         going = topple_row(i & 1);
      end
      res.length_rows = LEN_W'(len);
      res.toppling_count = topples;
      res.touched_area = AREA_W'(area);
      res.max_width = WIDTH_W'(widest);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pile_reset();
         avalanche_q.delete();
         fail_count <= 0;
         pending_count <= 0;
         results_seen <= 0;
      end else begin
         if (csr_wr_en) divisor = csr_wr_data;
         if (req_valid && req_ready) avalanche_q.push_back(run_avalanche(req_data));
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (avalanche_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               rsp_type exp;
               exp = avalanche_q.pop_front();
               if (exp.length_rows !== rsp_data.length_rows ||
                   exp.toppling_count !== rsp_data.toppling_count ||
                   exp.touched_area !== rsp_data.touched_area ||
                   exp.max_width !== rsp_data.max_width) begin
                  $display("%0t: expected %p, actual %p", $time, exp, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= avalanche_q.size();
      end
   end

endmodule

// ----- tb/stochastic_sandpile_avalanche_top_test.sv -----
// Testbench top for the sandpile avalanche block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module stochastic_sandpile_avalanche_top_test;
   import ssa_pkg::*;

   localparam int CYCLE_LIMIT = 400000000;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 0;
   logic [DIV_W-1:0] csr_wr_data = '0;
   int               fail_count, pending_count, results_seen;
   int               cycles = 0;
   int               sent = 0;
   bit               calm = 0;

   stochastic_sandpile_avalanche_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   stochastic_sandpile_avalanche_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count), .results_seen(results_seen)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(99) >= 8);

   task automatic send_request(bit reseed, logic [31:0] seed);
      req_valid <= 1;
      req_data <= '{reseed: reseed, seed_value: seed};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (!calm && $urandom_range(99) < 8) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0 || rsp_valid) @(posedge clock);
   endtask

   task automatic set_divisor(logic [DIV_W-1:0] z);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= z;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic random_phase(int count);
      for (int k = 0; k < count; k++)
         send_request($urandom_range(3) == 0, $urandom);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      send_request(0, 0);
      send_request(1, 0);
      send_request(1, 1);
      send_request(1, 32'hFFFF_FFFF);
      send_request(1, 32'h8000_0000);
      send_request(0, 32'h1234_5678);
      set_divisor(4);
      send_request(1, 32'h5555_5555);
      send_request(1, 32'hAAAA_AAAA);
      set_divisor(0);
      send_request(1, 32'hDEAD_BEEF);
      send_request(0, 0);
      set_divisor(1);
      send_request(0, 0);
      set_divisor(2);
      send_request(0, 0);
      send_request(1, 7);
      set_divisor(31);
      send_request(0, 0);
      send_request(1, 3);
      set_divisor(3);
      send_request(0, 0);
      set_divisor(16);
      send_request(0, 0);

      set_divisor(3);
      random_phase(20);
      set_divisor(16);
      random_phase(15);
      set_divisor(DIV_W'($urandom_range(3, 16)));
      calm = 1;
      random_phase(30);
      calm = 0;
      set_divisor(DIV_W'($urandom_range(3, 16)));
      random_phase(20);
      set_divisor(4);
      random_phase(15);
      set_divisor(DIV_W'($urandom_range(0, 31)));
      random_phase(20);

      drain();
      repeat (200) @(posedge clock);
      $display("Sent %0d requests, checked %0d avalanches", sent, results_seen);
      $display("Divisor settings 0, 1, 2, 3, 4, 16, 31 and random values, with reseeds");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
